### rtl/kab_pkg.sv
// Shared types, codes and helpers for the two-state angle/bias Kalman filter.
// Used by kab_div, kab_ctrl, kab_dp and kalman_angle_bias_filter; no dependencies.
package kab_pkg;

    localparam int unsigned NoiseW   = 24;
    localparam int unsigned MeasW    = 25;
    localparam int unsigned RateW    = 29;
    localparam int unsigned DtW      = 16;
    localparam int unsigned DivSteps = 56;

    localparam logic [NoiseW-1:0] AngleNoiseRst   = 24'd16777;
    localparam logic [NoiseW-1:0] BiasNoiseRst    = 24'd50332;
    localparam logic [NoiseW-1:0] MeasureNoiseRst = 24'd503316;

    localparam logic [1:0] CFG_ANGLE_NOISE   = 2'd0;
    localparam logic [1:0] CFG_BIAS_NOISE    = 2'd1;
    localparam logic [1:0] CFG_MEASURE_NOISE = 2'd2;

    typedef enum logic [3:0] {
        MUL_NONE,
        MUL_DT_RATE,
        MUL_DT_P11,
        MUL_DT_INNER,
        MUL_QB_DT,
        MUL_K0_Y,
        MUL_K1_Y,
        MUL_K0_T00,
        MUL_K0_T01,
        MUL_K1_T00,
        MUL_K1_T01
    } mul_op_t;

    typedef enum logic [3:0] {
        WB_NONE,
        WB_ANGLE_PRED,
        WB_DTP11,
        WB_INNER,
        WB_P_PRED,
        WB_P11_PRED,
        WB_SETUP,
        WB_K0,
        WB_K1,
        WB_ANGLE_COR,
        WB_BIAS_COR,
        WB_P00_COR,
        WB_P01_COR,
        WB_P10_COR,
        WB_P11_COR
    } wb_op_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_PRED_RATE,
        ST_PRED_ANGLE,
        ST_PRED_DTP11,
        ST_PRED_INNER,
        ST_PRED_P00,
        ST_PRED_P,
        ST_PRED_P11,
        ST_SETUP,
        ST_DIV0_GO,
        ST_DIV0_WAIT,
        ST_DIV1_GO,
        ST_DIV1_WAIT,
        ST_COR_Y0,
        ST_COR_Y1,
        ST_COR_T0,
        ST_COR_T1,
        ST_COR_T2,
        ST_COR_T3,
        ST_COR_T4,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic    load;
        mul_op_t mul_op;
        wb_op_t  wb_op;
        logic    div_start;
        logic    div_sel;
        logic    out_load;
    } kab_cmd_t;

    typedef struct packed {
        logic div_busy;
    } kab_status_t;

    // Clamp a wide signed value to signed 32 bits.
    function automatic logic signed [31:0] sat32(input logic signed [69:0] v);
        logic all_zero;
        logic all_one;
        all_zero = ~|v[69:31];
        all_one  = &v[69:31];
        if (all_zero || all_one)
            return v[31:0];
        else if (v[69])
            return 32'sh8000_0000;
        else
            return 32'sh7FFF_FFFF;
    endfunction

endpackage

### rtl/kab_div.sv
// Serial restoring divider for the Kalman gains: (num * 2^24) / den, one bit a cycle.
// Depends on kab_pkg.
module kab_div (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic signed [31:0] num,
    input  logic signed [32:0] den,
    output logic               busy,
    output logic signed [31:0] quot
);
    import kab_pkg::*;

    logic               busy_reg, busy_next;
    logic [5:0]         cnt_reg, cnt_next;
    logic [55:0]        qd_reg, qd_next;
    logic [33:0]        rem_reg, rem_next;
    logic [33:0]        dmag_reg, dmag_next;
    logic               neg_reg, neg_next;
    logic               zero_reg, zero_next;
    logic signed [31:0] quot_reg, quot_next;

    logic [31:0]        num_mag;
    logic [33:0]        den_mag;
    logic [34:0]        rem_shift;
    logic               fits;
    logic signed [56:0] q_signed;

    always_comb
    begin
        num_mag   = num[31] ? 32'(-num) : 32'(num);
        den_mag   = den[32] ? 34'(-35'(den)) : 34'(den);
        rem_shift = {rem_reg, qd_reg[55]};
        fits      = rem_shift >= {1'b0, dmag_reg};
        q_signed  = neg_reg ? -$signed({1'b0, qd_reg}) : $signed({1'b0, qd_reg});

        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        qd_next   = qd_reg;
        rem_next  = rem_reg;
        dmag_next = dmag_reg;
        neg_next  = neg_reg;
        zero_next = zero_reg;
        quot_next = quot_reg;

        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = 6'(DivSteps);
            qd_next   = {num_mag, 24'd0};
            rem_next  = '0;
            dmag_next = den_mag;
            neg_next  = num[31] ^ den[32];
            zero_next = (den == '0);
        end
        else if (busy_reg)
        begin
            if (cnt_reg != '0)
            begin
                // shift in the next dividend bit, subtract where the divisor fits
                rem_next = fits ? 34'(rem_shift - {1'b0, dmag_reg}) : rem_shift[33:0];
                qd_next  = {qd_reg[54:0], fits};
                cnt_next = cnt_reg - 6'd1;
            end
            else
            begin
                quot_next = zero_reg ? '0 : sat32(70'(q_signed));
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        qd_reg   <= qd_next;
        rem_reg  <= rem_next;
        dmag_reg <= dmag_next;
        neg_reg  <= neg_next;
        zero_reg <= zero_next;
        quot_reg <= quot_next;
    end

    assign busy = busy_reg;
    assign quot = quot_reg;

endmodule

### rtl/kab_ctrl.sv
// Sequencer for one filter step: predict, two gain divisions, correct, hand off.
// Depends on kab_pkg.
module kab_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    output logic                 out_valid,
    input  logic                 out_ready,
    output kab_pkg::kab_cmd_t    cmd,
    input  kab_pkg::kab_status_t status
);
    import kab_pkg::*;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        cmd.load      = 1'b0;
        cmd.mul_op    = MUL_NONE;
        cmd.wb_op     = WB_NONE;
        cmd.div_start = 1'b0;
        cmd.div_sel   = 1'b0;
        cmd.out_load  = 1'b0;
        in_ready      = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_PRED_RATE;
                end
            end
            ST_PRED_RATE:
            begin
                cmd.mul_op = MUL_DT_RATE;
                state_next = ST_PRED_ANGLE;
            end
            ST_PRED_ANGLE:
            begin
                cmd.wb_op  = WB_ANGLE_PRED;
                cmd.mul_op = MUL_DT_P11;
                state_next = ST_PRED_DTP11;
            end
            ST_PRED_DTP11:
            begin
                cmd.wb_op  = WB_DTP11;
                state_next = ST_PRED_INNER;
            end
            ST_PRED_INNER:
            begin
                cmd.wb_op  = WB_INNER;
                state_next = ST_PRED_P00;
            end
            ST_PRED_P00:
            begin
                cmd.mul_op = MUL_DT_INNER;
                state_next = ST_PRED_P;
            end
            ST_PRED_P:
            begin
                cmd.wb_op  = WB_P_PRED;
                cmd.mul_op = MUL_QB_DT;
                state_next = ST_PRED_P11;
            end
            ST_PRED_P11:
            begin
                cmd.wb_op  = WB_P11_PRED;
                state_next = ST_SETUP;
            end
            ST_SETUP:
            begin
                cmd.wb_op  = WB_SETUP;
                state_next = ST_DIV0_GO;
            end
            ST_DIV0_GO:
            begin
                cmd.div_start = 1'b1;
                state_next    = ST_DIV0_WAIT;
            end
            ST_DIV0_WAIT:
            begin
                if (!status.div_busy)
                begin
                    cmd.wb_op  = WB_K0;
                    state_next = ST_DIV1_GO;
                end
            end
            ST_DIV1_GO:
            begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = 1'b1;
                state_next    = ST_DIV1_WAIT;
            end
            ST_DIV1_WAIT:
            begin
                if (!status.div_busy)
                begin
                    cmd.wb_op  = WB_K1;
                    state_next = ST_COR_Y0;
                end
            end
            ST_COR_Y0:
            begin
                cmd.mul_op = MUL_K0_Y;
                state_next = ST_COR_Y1;
            end
            ST_COR_Y1:
            begin
                cmd.wb_op  = WB_ANGLE_COR;
                cmd.mul_op = MUL_K1_Y;
                state_next = ST_COR_T0;
            end
            ST_COR_T0:
            begin
                cmd.wb_op  = WB_BIAS_COR;
                cmd.mul_op = MUL_K0_T00;
                state_next = ST_COR_T1;
            end
            ST_COR_T1:
            begin
                cmd.wb_op  = WB_P00_COR;
                cmd.mul_op = MUL_K0_T01;
                state_next = ST_COR_T2;
            end
            ST_COR_T2:
            begin
                cmd.wb_op  = WB_P01_COR;
                cmd.mul_op = MUL_K1_T00;
                state_next = ST_COR_T3;
            end
            ST_COR_T3:
            begin
                cmd.wb_op  = WB_P10_COR;
                cmd.mul_op = MUL_K1_T01;
                state_next = ST_COR_T4;
            end
            ST_COR_T4:
            begin
                cmd.wb_op  = WB_P11_COR;
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                // hold until the output register is free
                if (!out_valid_reg || out_ready)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (cmd.out_load)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    assign out_valid = out_valid_reg;

endmodule

### rtl/kab_dp.sv
// Filter datapath: state registers, one shared multiplier, rounding, saturation,
// gain divider and output register. Depends on kab_pkg and kab_div.
module kab_dp (
    input  logic                 clk,
    input  logic                 rst_n,
    input  kab_pkg::kab_cmd_t    cmd,
    output kab_pkg::kab_status_t status,
    input  logic signed [24:0]   measured_angle,
    input  logic signed [28:0]   gyro_rate,
    input  logic [15:0]          time_step,
    input  logic [23:0]          angle_noise_var,
    input  logic [23:0]          bias_noise_var,
    input  logic [23:0]          measure_noise_var,
    output logic signed [31:0]   filtered_angle,
    output logic signed [31:0]   rate_bias
);
    import kab_pkg::*;

    // filter state
    logic signed [31:0] angle_reg, angle_next;
    logic signed [31:0] bias_reg, bias_next;
    logic signed [31:0] p00_reg, p00_next;
    logic signed [31:0] p01_reg, p01_next;
    logic signed [31:0] p10_reg, p10_next;
    logic signed [31:0] p11_reg, p11_next;

    // per-step working registers
    logic signed [24:0] meas_reg, meas_next;
    logic [15:0]        dt_reg, dt_next;
    logic signed [33:0] rmb_reg, rmb_next;
    logic signed [32:0] dtp11_reg, dtp11_next;
    logic signed [34:0] inner_reg, inner_next;
    logic signed [32:0] s_reg, s_next;
    logic signed [31:0] y_reg, y_next;
    logic signed [31:0] t00_reg, t00_next;
    logic signed [31:0] t01_reg, t01_next;
    logic signed [31:0] k0_reg, k0_next;
    logic signed [31:0] k1_reg, k1_next;
    logic signed [67:0] prod_reg, prod_next;
    logic signed [31:0] oangle_reg, oangle_next;
    logic signed [31:0] obias_reg, obias_next;

    logic signed [34:0] mul_a;
    logic signed [32:0] mul_b;
    logic signed [32:0] dt_s;
    logic signed [67:0] r16;
    logic signed [67:0] r24;
    logic               div_busy;
    logic signed [31:0] div_quot;
    logic signed [31:0] div_num;

    assign dt_s    = $signed({17'd0, dt_reg});
    assign r16     = (prod_reg + 68'sd32768) >>> 16;
    assign r24     = (prod_reg + 68'sd8388608) >>> 24;
    assign div_num = cmd.div_sel ? p10_reg : p00_reg;

    kab_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.div_start),
        .num   (div_num),
        .den   (s_reg),
        .busy  (div_busy),
        .quot  (div_quot)
    );

    assign status.div_busy = div_busy;

    // operand select for the shared multiplier
    always_comb
    begin
        case (cmd.mul_op)
            MUL_DT_RATE:  begin mul_a = 35'(rmb_reg);                 mul_b = dt_s;          end
            MUL_DT_P11:   begin mul_a = 35'(p11_reg);                 mul_b = dt_s;          end
            MUL_DT_INNER: begin mul_a = inner_reg;                    mul_b = dt_s;          end
            MUL_QB_DT:    begin mul_a = $signed({11'd0, bias_noise_var}); mul_b = dt_s;      end
            MUL_K0_Y:     begin mul_a = 35'(k0_reg);                  mul_b = 33'(y_reg);    end
            MUL_K1_Y:     begin mul_a = 35'(k1_reg);                  mul_b = 33'(y_reg);    end
            MUL_K0_T00:   begin mul_a = 35'(k0_reg);                  mul_b = 33'(t00_reg);  end
            MUL_K0_T01:   begin mul_a = 35'(k0_reg);                  mul_b = 33'(t01_reg);  end
            MUL_K1_T00:   begin mul_a = 35'(k1_reg);                  mul_b = 33'(t00_reg);  end
            MUL_K1_T01:   begin mul_a = 35'(k1_reg);                  mul_b = 33'(t01_reg);  end
            default:      begin mul_a = '0;                           mul_b = '0;            end
        endcase
    end

    always_comb
    begin
        angle_next  = angle_reg;
        bias_next   = bias_reg;
        p00_next    = p00_reg;
        p01_next    = p01_reg;
        p10_next    = p10_reg;
        p11_next    = p11_reg;
        meas_next   = meas_reg;
        dt_next     = dt_reg;
        rmb_next    = rmb_reg;
        dtp11_next  = dtp11_reg;
        inner_next  = inner_reg;
        s_next      = s_reg;
        y_next      = y_reg;
        t00_next    = t00_reg;
        t01_next    = t01_reg;
        k0_next     = k0_reg;
        k1_next     = k1_reg;
        oangle_next = oangle_reg;
        obias_next  = obias_reg;
        prod_next   = 68'(mul_a) * 68'(mul_b);

        if (cmd.load)
        begin
            meas_next = measured_angle;
            dt_next   = time_step;
            rmb_next  = 34'(gyro_rate) - 34'(bias_reg);
        end

        if (cmd.out_load)
        begin
            oangle_next = angle_reg;
            obias_next  = bias_reg;
        end

        case (cmd.wb_op)
            WB_NONE: ;
            WB_ANGLE_PRED: angle_next = sat32(70'(angle_reg) + 70'(r16));
            WB_DTP11:      dtp11_next = r16[32:0];
            WB_INNER:
                inner_next = 35'(dtp11_reg) - 35'(p01_reg) - 35'(p10_reg)
                           + $signed({11'd0, angle_noise_var});
            WB_P_PRED:
            begin
                p00_next = sat32(70'(p00_reg) + 70'(r16));
                p01_next = sat32(70'(p01_reg) - 70'(dtp11_reg));
                p10_next = sat32(70'(p10_reg) - 70'(dtp11_reg));
            end
            WB_P11_PRED:   p11_next = sat32(70'(p11_reg) + 70'(r16));
            WB_SETUP:
            begin
                s_next   = 33'(p00_reg) + $signed({9'd0, measure_noise_var});
                y_next   = sat32(70'(meas_reg) - 70'(angle_reg));
                t00_next = p00_reg;
                t01_next = p01_reg;
            end
            WB_K0:         k0_next    = div_quot;
            WB_K1:         k1_next    = div_quot;
            WB_ANGLE_COR:  angle_next = sat32(70'(angle_reg) + 70'(r24));
            WB_BIAS_COR:   bias_next  = sat32(70'(bias_reg) + 70'(r24));
            WB_P00_COR:    p00_next   = sat32(70'(p00_reg) - 70'(r24));
            WB_P01_COR:    p01_next   = sat32(70'(p01_reg) - 70'(r24));
            WB_P10_COR:    p10_next   = sat32(70'(p10_reg) - 70'(r24));
            WB_P11_COR:    p11_next   = sat32(70'(p11_reg) - 70'(r24));
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            angle_reg <= '0;
            bias_reg  <= '0;
            p00_reg   <= '0;
            p01_reg   <= '0;
            p10_reg   <= '0;
            p11_reg   <= '0;
        end
        else
        begin
            angle_reg <= angle_next;
            bias_reg  <= bias_next;
            p00_reg   <= p00_next;
            p01_reg   <= p01_next;
            p10_reg   <= p10_next;
            p11_reg   <= p11_next;
        end
    end

    always_ff @(posedge clk)
    begin
        meas_reg   <= meas_next;
        dt_reg     <= dt_next;
        rmb_reg    <= rmb_next;
        dtp11_reg  <= dtp11_next;
        inner_reg  <= inner_next;
        s_reg      <= s_next;
        y_reg      <= y_next;
        t00_reg    <= t00_next;
        t01_reg    <= t01_next;
        k0_reg     <= k0_next;
        k1_reg     <= k1_next;
        prod_reg   <= prod_next;
        oangle_reg <= oangle_next;
        obias_reg  <= obias_next;
    end

    assign filtered_angle = oangle_reg;
    assign rate_bias      = obias_reg;

endmodule

### rtl/kalman_angle_bias_filter.sv
// Top level of the two-state angle/bias Kalman filter: stream ports, noise registers,
// sequencer and datapath. Depends on kab_pkg, kab_ctrl, kab_dp (and kab_div below it).
//
//   channel  direction  handshake          payload
//   s_*      in         s_tvalid/s_tready  measured_angle, gyro_rate, time_step
//   m_*      out        m_tvalid/m_tready  filtered_angle, rate_bias
//   apb      in         psel/penable       noise variance registers 0x0, 0x4, 0x8
//
// The time from one input transfer to the next while the output is free is set mostly
// by the serial gain divider (two divisions, start state included) plus the shared
// multiplier's sequence; m_tvalid rises as the finished step enters the output register.
// A new sample is taken only once the previous one has reached the output register.
// A stalled m_tready holds the finished step in its last state; reset clears
// estimates and covariance and restores the noise defaults.
module kalman_angle_bias_filter (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // [24:0] measured_angle, [53:25] gyro_rate, [69:54] time_step, [71:70] zero
    input  logic [71:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // [31:0] filtered_angle, [63:32] rate_bias
    output logic [63:0] m_tdata,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import kab_pkg::*;

    logic [NoiseW-1:0] angle_noise_reg, angle_noise_next;
    logic [NoiseW-1:0] bias_noise_reg, bias_noise_next;
    logic [NoiseW-1:0] meas_noise_reg, meas_noise_next;
    logic              cfg_write;
    logic [1:0]        cfg_idx;

    kab_cmd_t           cmd;
    kab_status_t        status;
    logic signed [31:0] filtered_angle;
    logic signed [31:0] rate_bias;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign cfg_idx   = paddr[3:2];

    always_comb
    begin
        angle_noise_next = angle_noise_reg;
        bias_noise_next  = bias_noise_reg;
        meas_noise_next  = meas_noise_reg;
        if (cfg_write)
        begin
            case (cfg_idx)
                CFG_ANGLE_NOISE:   angle_noise_next = pwdata[NoiseW-1:0];
                CFG_BIAS_NOISE:    bias_noise_next  = pwdata[NoiseW-1:0];
                CFG_MEASURE_NOISE: meas_noise_next  = pwdata[NoiseW-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (cfg_idx)
            CFG_ANGLE_NOISE:   prdata = {8'd0, angle_noise_reg};
            CFG_BIAS_NOISE:    prdata = {8'd0, bias_noise_reg};
            CFG_MEASURE_NOISE: prdata = {8'd0, meas_noise_reg};
            default:           prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            angle_noise_reg <= AngleNoiseRst;
            bias_noise_reg  <= BiasNoiseRst;
            meas_noise_reg  <= MeasureNoiseRst;
        end
        else
        begin
            angle_noise_reg <= angle_noise_next;
            bias_noise_reg  <= bias_noise_next;
            meas_noise_reg  <= meas_noise_next;
        end
    end

    kab_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .cmd       (cmd),
        .status    (status)
    );

    kab_dp u_dp (
        .clk               (clk),
        .rst_n             (rst_n),
        .cmd               (cmd),
        .status            (status),
        .measured_angle    ($signed(s_tdata[24:0])),
        .gyro_rate         ($signed(s_tdata[53:25])),
        .time_step         (s_tdata[69:54]),
        .angle_noise_var   (angle_noise_reg),
        .bias_noise_var    (bias_noise_reg),
        .measure_noise_var (meas_noise_reg),
        .filtered_angle    (filtered_angle),
        .rate_bias         (rate_bias)
    );

    assign m_tdata = {rate_bias, filtered_angle};

endmodule
